// ----- rtl/core/lla_pkg.sv -----
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and constants for the life-like automaton step block.
// ----------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

	// Field widths of the command and response transactions
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned COORD_W = 6;
	localparam int unsigned MASK_W  = 9;
	localparam int unsigned CNT_W   = 4;  // neighbor count 0..8

	// Configuration port
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = CFG_IDX_W'(1);

	localparam logic [MASK_W-1:0] BIRTH_RST   = MASK_W'(8);   // B3
	localparam logic [MASK_W-1:0] SURVIVE_RST = MASK_W'(12);  // S23

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lla_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lla_cmd_if
// Command channel: operation code, cell address and write value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lla_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [lla_pkg::FUNC_W-1:0]  func;
	logic [lla_pkg::COORD_W-1:0] cell_col;
	logic [lla_pkg::COORD_W-1:0] cell_row;
	logic                        write_value;

	modport source (
		output valid, func, cell_col, cell_row, write_value,
		input  ready
	);

	modport sink (
		input  valid, func, cell_col, cell_row, write_value,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/lla_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lla_rsp_if
// Response channel: one cell value per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface lla_rsp_if;
	logic valid;
	logic ready;
	logic cell_value;

	modport source (
		output valid, cell_value,
		input  ready
	);

	modport sink (
		input  valid, cell_value,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/lla_row_cell.sv -----
// ----------------------------------------------------------------------------
// lla_row_cell
// One link of the row ring: holds one grid row, takes its neighbor's row on a step.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_row_cell #(
	parameter int unsigned ROW_W = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift_en,
	input  wire logic [ROW_W-1:0] row_d,
	output logic      [ROW_W-1:0] row_q
);

	// Grid resets to all cells dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift_en) begin
			row_q <= row_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/lla_row_rule.sv -----
// ----------------------------------------------------------------------------
// lla_row_rule
// Next-generation value of one row from the rows above, at and below it.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_row_rule #(
	parameter int unsigned ROW_W = 64
) (
	input  wire logic [ROW_W-1:0]           row_up,
	input  wire logic [ROW_W-1:0]           row_mid,
	input  wire logic [ROW_W-1:0]           row_dn,
	input  wire logic [lla_pkg::MASK_W-1:0] birth_mask,
	input  wire logic [lla_pkg::MASK_W-1:0] survive_mask,
	output logic      [ROW_W-1:0]           row_nxt
);

	import lla_pkg::*;

	for (genvar c = 0; c < ROW_W; c++) begin : g_col
		// Wrapped column neighbors
		localparam int unsigned LF = (c == 0) ? ROW_W - 1 : c - 1;
		localparam int unsigned RT = (c == ROW_W - 1) ? 0 : c + 1;

		logic [CNT_W-1:0]  cnt;
		logic [MASK_W-1:0] rule;

		assign cnt = CNT_W'(row_up[LF]) + CNT_W'(row_up[c]) + CNT_W'(row_up[RT])
		           + CNT_W'(row_mid[LF]) + CNT_W'(row_mid[RT])
		           + CNT_W'(row_dn[LF]) + CNT_W'(row_dn[c]) + CNT_W'(row_dn[RT]);

		assign rule       = row_mid[c] ? survive_mask : birth_mask;
		assign row_nxt[c] = rule[cnt];
	end

endmodule

`default_nettype wire

// ----- rtl/core/life_like_automaton_step_top.sv -----
// ----------------------------------------------------------------------------
// life_like_automaton_step_top
// Toroidal life-like cellular automaton with cell write/read, clear and step.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one transaction per operation: func selects write cell, read
//   cell, advance one generation or clear grid; cell_row/cell_col address the
//   cell for write and read, write_value is the stored value. Addresses at or
//   beyond GRID_SIZE are ignored (a read then answers 0).
//   rsp returns exactly one transaction per command: the cell value for a
//   read, 0 for every other operation.
//   cfg_we/cfg_idx/cfg_wdata write birth_mask (index 0) or survive_mask
//   (index 1); other indexes are dropped. Write them only while idle.
// Timing:
//   The grid lives in a ring of GRID_SIZE row cells. Every operation rotates
//   the ring once around, one row per cycle unless the final step is held
//   (see Stall), and touches the row at its head. A new command is taken
//   only once the ring turn of the previous one is complete, and rsp.valid
//   rises when the final ring step is taken.
// Reset:
//   arst_n clears the grid to all dead, the masks to B3/S23 and all handshakes.
// Stall:
//   The response sits in an output register; the next command is accepted
//   while it waits. If it is still unclaimed when the following operation
//   finishes, the ring holds at its last step until rsp.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_step_top #(
	parameter int unsigned GRID_SIZE = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	lla_cmd_if.sink                                cmd,
	lla_rsp_if.source                              rsp,
	input  wire logic                              cfg_we,
	input  wire logic [lla_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [lla_pkg::MASK_W-1:0]        cfg_wdata
);

	import lla_pkg::*;

	localparam int unsigned TW    = $clog2(GRID_SIZE);
	localparam int unsigned CMP_W = ((TW > COORD_W) ? TW : COORD_W) + 1;

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t            state_q, state_d;
	logic [TW-1:0]     step_q;
	logic              step_en;
	logic              step_last;
	logic              cmd_acc;

	// Captured command
	func_t             op_func_q;
	logic [COORD_W-1:0] op_col_q;
	logic [COORD_W-1:0] op_row_q;
	logic              op_wval_q;

	// Rule masks
	logic [MASK_W-1:0] birth_q;
	logic [MASK_W-1:0] survive_q;

	// Response register
	logic              rsp_valid_q;
	logic              rsp_value_q;
	logic              rd_q;
	logic              rd_next;

	// Ring datapath
	logic [GRID_SIZE-1:0] rows [GRID_SIZE];
	logic [GRID_SIZE-1:0] head;
	logic [GRID_SIZE-1:0] prev_q;
	logic [GRID_SIZE-1:0] first_q;
	logic [GRID_SIZE-1:0] row_up;
	logic [GRID_SIZE-1:0] row_dn;
	logic [GRID_SIZE-1:0] row_nxt;
	logic [GRID_SIZE-1:0] tail;

	logic              row_in;
	logic              col_in;
	logic              hit;
	logic [TW-1:0]     col_idx;

	assign cmd_acc   = cmd.valid & cmd.ready;
	assign step_last = (step_q == TW'(GRID_SIZE - 1));

	// ------------------------------------------------------------------
	// Sequencer: idle until a command arrives, then one full ring turn
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		step_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				// Hold the final step while the previous response is unclaimed
				step_en = !(step_last && rsp_valid_q && !rsp.ready);
				if (step_en && step_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (step_en) begin
			step_q <= step_last ? '0 : step_q + TW'(1);
		end
	end

	// Capture the command payload on acceptance
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_func_q <= func_t'(cmd.func);
			op_col_q  <= cmd.cell_col;
			op_row_q  <= cmd.cell_row;
			op_wval_q <= cmd.write_value;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q   <= BIRTH_RST;
			survive_q <= SURVIVE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_BIRTH:   birth_q   <= cfg_wdata;
				CFG_SURVIVE: survive_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Row ring: cell k takes cell k+1; the last cell takes the processed head
	// ------------------------------------------------------------------
	for (genvar k = 0; k < GRID_SIZE; k++) begin : g_ring
		if (k == GRID_SIZE - 1) begin : g_tail
			lla_row_cell #(.ROW_W(GRID_SIZE)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (step_en),
				.row_d    (tail),
				.row_q    (rows[k])
			);
		end else begin : g_link
			lla_row_cell #(.ROW_W(GRID_SIZE)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (step_en),
				.row_d    (rows[k+1]),
				.row_q    (rows[k])
			);
		end
	end

	assign head = rows[0];

	// At step t the head holds old row t. The row above is the last cell on
	// the first step (still old) and the saved head afterwards; the row below
	// is cell 1, except on the last step where old row 0 was kept aside.
	assign row_up = (step_q == '0) ? rows[GRID_SIZE-1] : prev_q;
	assign row_dn = step_last ? first_q : rows[1];

	always_ff @(posedge clk) begin
		if (step_en) begin
			prev_q <= head;
			if (step_q == '0) begin
				first_q <= head;
			end
		end
	end

	lla_row_rule #(.ROW_W(GRID_SIZE)) u_rule (
		.row_up       (row_up),
		.row_mid      (head),
		.row_dn       (row_dn),
		.birth_mask   (birth_q),
		.survive_mask (survive_q),
		.row_nxt      (row_nxt)
	);

	// Addressed cell: the head row matches the row address, both in range
	assign row_in  = CMP_W'(op_row_q) < CMP_W'(GRID_SIZE);
	assign col_in  = CMP_W'(op_col_q) < CMP_W'(GRID_SIZE);
	assign hit     = row_in && col_in && (CMP_W'(step_q) == CMP_W'(op_row_q));
	assign col_idx = TW'(op_col_q);

	always_comb begin
		tail = head;
		case (op_func_q)
			FUNC_WRITE: begin
				for (int unsigned c = 0; c < GRID_SIZE; c++) begin
					if (hit && (col_idx == TW'(c))) begin
						tail[c] = op_wval_q;
					end
				end
			end
			FUNC_READ:    tail = head;
			FUNC_ADVANCE: tail = row_nxt;
			FUNC_CLEAR:   tail = '0;
			default:      tail = head;
		endcase
	end

	// ------------------------------------------------------------------
	// Read capture and response register
	// ------------------------------------------------------------------
	assign rd_next = ((op_func_q == FUNC_READ) && hit) ? head[col_idx] : rd_q;

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			rd_q <= 1'b0;
		end else if (step_en) begin
			rd_q <= rd_next;
		end
		if (step_en && step_last) begin
			rsp_value_q <= rd_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step_en && step_last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cell_value = rsp_value_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_step_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (step_q == '0))
		else $error("step counter not at zero while idle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> ((state_q == ST_SWEEP) && (step_q == '0)))
		else $error("accepted command did not start a sweep at row zero");

	a_rsp_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(step_en && step_last))
		else $error("response raised outside the final ring step");

	a_value_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(rsp_valid_q) && rsp_value_q) |-> (op_func_q == FUNC_READ))
		else $error("nonzero response for an operation other than read");

endmodule

`default_nettype wire
